FILE: rtl/acg_pkg.sv
package acg_pkg;

    // Width of every coordinate and penetration field at the ports
    localparam int FIELD_WIDTH = 32;

    // Number of spatial axes
    localparam int AXES = 3;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Load strobes, one per pipeline stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_load_t;

endpackage

FILE: rtl/acg_overlap.sv
module acg_overlap #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  acg_pkg::stage_load_t                  load,
    input  logic [acg_pkg::FIELD_WIDTH-1:0]       a_min [acg_pkg::AXES],
    input  logic [acg_pkg::FIELD_WIDTH-1:0]       a_max [acg_pkg::AXES],
    input  logic [acg_pkg::FIELD_WIDTH-1:0]       b_min [acg_pkg::AXES],
    input  logic [acg_pkg::FIELD_WIDTH-1:0]       b_max [acg_pkg::AXES],
    output logic                                  hit,
    output logic signed [COORD_WIDTH:0]           pen [acg_pkg::AXES],
    output logic signed [COORD_WIDTH:0]           sum_a [acg_pkg::AXES],
    output logic signed [COORD_WIDTH:0]           sum_b [acg_pkg::AXES],
    output logic signed [COORD_WIDTH-1:0]         a_lo [acg_pkg::AXES],
    output logic signed [COORD_WIDTH-1:0]         a_hi [acg_pkg::AXES]
);
    import acg_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int EW = (CW > FIELD_WIDTH) ? CW : FIELD_WIDTH;

    logic [EW-1:0]             amin_e [AXES];
    logic [EW-1:0]             amax_e [AXES];
    logic [EW-1:0]             bmin_e [AXES];
    logic [EW-1:0]             bmax_e [AXES];
    logic signed [CW-1:0]      amin [AXES];
    logic signed [CW-1:0]      amax [AXES];
    logic signed [CW-1:0]      bmin [AXES];
    logic signed [CW-1:0]      bmax [AXES];
    logic signed [CW-1:0]      upper [AXES];
    logic signed [CW-1:0]      lower [AXES];
    logic [AXES-1:0]           axis_hit;

    logic                      hit_reg;
    logic signed [CW:0]        pen_reg [AXES];
    logic signed [CW:0]        pen_next [AXES];
    logic signed [CW:0]        sum_a_reg [AXES];
    logic signed [CW:0]        sum_a_next [AXES];
    logic signed [CW:0]        sum_b_reg [AXES];
    logic signed [CW:0]        sum_b_next [AXES];
    logic signed [CW-1:0]      a_lo_reg [AXES];
    logic signed [CW-1:0]      a_hi_reg [AXES];

    // Take the low coordinate bits of each field as a signed value
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            amin_e[i] = EW'(a_min[i]);
            amax_e[i] = EW'(a_max[i]);
            bmin_e[i] = EW'(b_min[i]);
            bmax_e[i] = EW'(b_max[i]);
            amin[i]   = signed'(amin_e[i][CW-1:0]);
            amax[i]   = signed'(amax_e[i][CW-1:0]);
            bmin[i]   = signed'(bmin_e[i][CW-1:0]);
            bmax[i]   = signed'(bmax_e[i][CW-1:0]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            axis_hit[i]   = (amax[i] > bmin[i]) && (amin[i] < bmax[i]);
            upper[i]      = (amax[i] < bmax[i]) ? amax[i] : bmax[i];
            lower[i]      = (amin[i] > bmin[i]) ? amin[i] : bmin[i];
            pen_next[i]   = (CW+1)'(upper[i]) - (CW+1)'(lower[i]);
            sum_a_next[i] = (CW+1)'(amin[i]) + (CW+1)'(amax[i]);
            sum_b_next[i] = (CW+1)'(bmin[i]) + (CW+1)'(bmax[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            hit_reg <= &axis_hit;
            for (int i = 0; i < AXES; i++)
            begin
                pen_reg[i]   <= pen_next[i];
                sum_a_reg[i] <= sum_a_next[i];
                sum_b_reg[i] <= sum_b_next[i];
                a_lo_reg[i]  <= amin[i];
                a_hi_reg[i]  <= amax[i];
            end
        end
    end

    assign hit   = hit_reg;
    assign pen   = pen_reg;
    assign sum_a = sum_a_reg;
    assign sum_b = sum_b_reg;
    assign a_lo  = a_lo_reg;
    assign a_hi  = a_hi_reg;

endmodule

FILE: rtl/acg_axis_select.sv
module acg_axis_select #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  acg_pkg::stage_load_t                  load,
    input  logic                                  hit,
    input  logic signed [COORD_WIDTH:0]           pen [acg_pkg::AXES],
    input  logic signed [COORD_WIDTH:0]           sum_a [acg_pkg::AXES],
    input  logic signed [COORD_WIDTH:0]           sum_b [acg_pkg::AXES],
    input  logic signed [COORD_WIDTH-1:0]         a_lo [acg_pkg::AXES],
    input  logic signed [COORD_WIDTH-1:0]         a_hi [acg_pkg::AXES],
    output logic                                  sel_hit,
    output acg_pkg::axis_t                        sel_axis,
    output logic signed [COORD_WIDTH:0]           sel_pen,
    output logic signed [COORD_WIDTH:0]           sel_sum_a,
    output logic signed [COORD_WIDTH:0]           sel_sum_b,
    output logic signed [COORD_WIDTH-1:0]         sel_lo,
    output logic signed [COORD_WIDTH-1:0]         sel_hi,
    output logic signed [COORD_WIDTH-1:0]         center [acg_pkg::AXES]
);
    import acg_pkg::*;

    localparam int CW = COORD_WIDTH;

    axis_t                 axis_next;
    logic signed [CW:0]    pen_xy;

    logic                  hit_reg;
    axis_t                 axis_reg;
    logic signed [CW:0]    pen_reg;
    logic signed [CW:0]    sum_a_reg;
    logic signed [CW:0]    sum_b_reg;
    logic signed [CW-1:0]  lo_reg;
    logic signed [CW-1:0]  hi_reg;
    logic signed [CW-1:0]  center_reg [AXES];

    // Least penetration; ties keep the earlier axis
    always_comb
    begin
        axis_next = AXIS_X;
        pen_xy    = pen[AXIS_X];
        if (pen[AXIS_Y] < pen[AXIS_X])
        begin
            axis_next = AXIS_Y;
            pen_xy    = pen[AXIS_Y];
        end
        if (pen[AXIS_Z] < pen_xy)
        begin
            axis_next = AXIS_Z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            hit_reg   <= hit;
            axis_reg  <= axis_next;
            pen_reg   <= pen[axis_next];
            sum_a_reg <= sum_a[axis_next];
            sum_b_reg <= sum_b[axis_next];
            lo_reg    <= a_lo[axis_next];
            hi_reg    <= a_hi[axis_next];
            // Floor of half the sum: drop the low bit of the sign-extended sum
            for (int i = 0; i < AXES; i++)
            begin
                center_reg[i] <= signed'(sum_a[i][CW:1]);
            end
        end
    end

    assign sel_hit   = hit_reg;
    assign sel_axis  = axis_reg;
    assign sel_pen   = pen_reg;
    assign sel_sum_a = sum_a_reg;
    assign sel_sum_b = sum_b_reg;
    assign sel_lo    = lo_reg;
    assign sel_hi    = hi_reg;
    assign center    = center_reg;

endmodule

FILE: rtl/acg_contact.sv
module acg_contact #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  acg_pkg::stage_load_t                  load,
    input  logic                                  sel_hit,
    input  acg_pkg::axis_t                        sel_axis,
    input  logic signed [COORD_WIDTH:0]           sel_pen,
    input  logic signed [COORD_WIDTH:0]           sel_sum_a,
    input  logic signed [COORD_WIDTH:0]           sel_sum_b,
    input  logic signed [COORD_WIDTH-1:0]         sel_lo,
    input  logic signed [COORD_WIDTH-1:0]         sel_hi,
    input  logic signed [COORD_WIDTH-1:0]         center [acg_pkg::AXES],
    output logic                                  colliding,
    output logic [1:0]                            normal_axis,
    output logic                                  normal_negative,
    output logic [acg_pkg::FIELD_WIDTH-1:0]       penetration,
    output logic signed [acg_pkg::FIELD_WIDTH-1:0] contact [acg_pkg::AXES]
);
    import acg_pkg::*;

    localparam int CW = COORD_WIDTH;

    // Stage 3: normal sign and unsaturated contact on the chosen axis
    logic                  neg_next;
    logic signed [CW+1:0]  c_neg;
    logic signed [CW+1:0]  c_pos;

    logic                  hit3_reg;
    axis_t                 axis3_reg;
    logic signed [CW:0]    pen3_reg;
    logic                  neg3_reg;
    logic signed [CW+1:0]  c_axis_reg;
    logic signed [CW-1:0]  center3_reg [AXES];

    always_comb
    begin
        neg_next = sel_sum_b < sel_sum_a;
        c_neg    = (CW+2)'(sel_lo) + (CW+2)'(sel_pen);
        c_pos    = (CW+2)'(sel_hi) - (CW+2)'(sel_pen);
    end

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            hit3_reg    <= sel_hit;
            axis3_reg   <= sel_axis;
            pen3_reg    <= sel_pen;
            neg3_reg    <= neg_next;
            c_axis_reg  <= neg_next ? c_neg : c_pos;
            center3_reg <= center;
        end
    end

    // Stage 4: saturate, clamp penetration, zero everything on a miss
    logic                  fits;
    logic signed [CW-1:0]  c_sat;
    logic [CW-1:0]         pen_u;
    logic signed [CW-1:0]  coord [AXES];

    logic                  colliding_reg;
    logic [1:0]            normal_axis_reg;
    logic                  normal_negative_reg;
    logic [FIELD_WIDTH-1:0] penetration_reg;
    logic signed [FIELD_WIDTH-1:0] contact_reg [AXES];

    always_comb
    begin
        fits = (c_axis_reg[CW+1:CW-1] == '0) || (c_axis_reg[CW+1:CW-1] == '1);
        if (fits)
        begin
            c_sat = c_axis_reg[CW-1:0];
        end
        else if (c_axis_reg[CW+1])
        begin
            c_sat = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            c_sat = {1'b0, {(CW-1){1'b1}}};
        end
        pen_u = pen3_reg[CW] ? '0 : pen3_reg[CW-1:0];
        for (int i = 0; i < AXES; i++)
        begin
            coord[i] = (axis3_reg == axis_t'(i)) ? c_sat : center3_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s4)
        begin
            colliding_reg <= hit3_reg;
            if (hit3_reg)
            begin
                normal_axis_reg     <= 2'(axis3_reg);
                normal_negative_reg <= neg3_reg;
                penetration_reg     <= FIELD_WIDTH'(pen_u);
                for (int i = 0; i < AXES; i++)
                begin
                    contact_reg[i] <= FIELD_WIDTH'(coord[i]);
                end
            end
            else
            begin
                normal_axis_reg     <= '0;
                normal_negative_reg <= 1'b0;
                penetration_reg     <= '0;
                for (int i = 0; i < AXES; i++)
                begin
                    contact_reg[i] <= '0;
                end
            end
        end
    end

    assign colliding       = colliding_reg;
    assign normal_axis     = normal_axis_reg;
    assign normal_negative = normal_negative_reg;
    assign penetration     = penetration_reg;
    assign contact         = contact_reg;

endmodule

FILE: rtl/aabb_contact_generator.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------------
// box      | box_valid / box_stall     | a_min_*, a_max_*, b_min_*, b_max_* (x, y, z)
// contact  | contact_valid / contact_stall | colliding, normal_axis, normal_negative,
//          |                           | penetration, contact_x/y/z
//
// One transaction enters per cycle while box_stall is low; results leave in the order they entered.
// Stages: overlap test and per-axis penetration, least-penetration axis,
// normal sign and contact add, saturation into the output register.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall holds only the stages that are full behind it, so bubbles are
// squeezed out and nothing is dropped or repeated.
module aabb_contact_generator #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   box_valid,
    output logic                                   box_stall,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] a_min_x,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] a_min_y,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] a_min_z,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] a_max_x,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] a_max_y,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] a_max_z,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] b_min_x,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] b_min_y,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] b_min_z,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] b_max_x,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] b_max_y,
    input  logic signed [acg_pkg::FIELD_WIDTH-1:0] b_max_z,

    output logic                                   contact_valid,
    input  logic                                   contact_stall,
    output logic                                   colliding,
    output logic [1:0]                             normal_axis,
    output logic                                   normal_negative,
    output logic [acg_pkg::FIELD_WIDTH-1:0]        penetration,
    output logic signed [acg_pkg::FIELD_WIDTH-1:0] contact_x,
    output logic signed [acg_pkg::FIELD_WIDTH-1:0] contact_y,
    output logic signed [acg_pkg::FIELD_WIDTH-1:0] contact_z
);
    import acg_pkg::*;

    localparam int CW = COORD_WIDTH;

    // Gather the ports into per-axis arrays
    logic [FIELD_WIDTH-1:0] a_min_f [AXES];
    logic [FIELD_WIDTH-1:0] a_max_f [AXES];
    logic [FIELD_WIDTH-1:0] b_min_f [AXES];
    logic [FIELD_WIDTH-1:0] b_max_f [AXES];

    assign a_min_f[AXIS_X] = a_min_x;
    assign a_min_f[AXIS_Y] = a_min_y;
    assign a_min_f[AXIS_Z] = a_min_z;
    assign a_max_f[AXIS_X] = a_max_x;
    assign a_max_f[AXIS_Y] = a_max_y;
    assign a_max_f[AXIS_Z] = a_max_z;
    assign b_min_f[AXIS_X] = b_min_x;
    assign b_min_f[AXIS_Y] = b_min_y;
    assign b_min_f[AXIS_Z] = b_min_z;
    assign b_max_f[AXIS_X] = b_max_x;
    assign b_max_f[AXIS_Y] = b_max_y;
    assign b_max_f[AXIS_Z] = b_max_z;

    // Pipeline control: a stage loads when it is empty or the one after it loads
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        v4_reg;
    stage_load_t load;

    always_comb
    begin
        load.s4 = !v4_reg || !contact_stall;
        load.s3 = !v3_reg || load.s4;
        load.s2 = !v2_reg || load.s3;
        load.s1 = !v1_reg || load.s2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load.s1)
            begin
                v1_reg <= box_valid;
            end
            if (load.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (load.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (load.s4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign box_stall     = !load.s1;
    assign contact_valid = v4_reg;

    // Stage 1: overlap test, penetration and center sums per axis
    logic                  s1_hit;
    logic signed [CW:0]    s1_pen [AXES];
    logic signed [CW:0]    s1_sum_a [AXES];
    logic signed [CW:0]    s1_sum_b [AXES];
    logic signed [CW-1:0]  s1_lo [AXES];
    logic signed [CW-1:0]  s1_hi [AXES];

    acg_overlap #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_overlap (
        .clk   (clk),
        .load  (load),
        .a_min (a_min_f),
        .a_max (a_max_f),
        .b_min (b_min_f),
        .b_max (b_max_f),
        .hit   (s1_hit),
        .pen   (s1_pen),
        .sum_a (s1_sum_a),
        .sum_b (s1_sum_b),
        .a_lo  (s1_lo),
        .a_hi  (s1_hi)
    );

    // Stage 2: pick the axis of least penetration, halve A's center sums
    logic                  s2_hit;
    axis_t                 s2_axis;
    logic signed [CW:0]    s2_pen;
    logic signed [CW:0]    s2_sum_a;
    logic signed [CW:0]    s2_sum_b;
    logic signed [CW-1:0]  s2_lo;
    logic signed [CW-1:0]  s2_hi;
    logic signed [CW-1:0]  s2_center [AXES];

    acg_axis_select #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_select (
        .clk       (clk),
        .load      (load),
        .hit       (s1_hit),
        .pen       (s1_pen),
        .sum_a     (s1_sum_a),
        .sum_b     (s1_sum_b),
        .a_lo      (s1_lo),
        .a_hi      (s1_hi),
        .sel_hit   (s2_hit),
        .sel_axis  (s2_axis),
        .sel_pen   (s2_pen),
        .sel_sum_a (s2_sum_a),
        .sel_sum_b (s2_sum_b),
        .sel_lo    (s2_lo),
        .sel_hi    (s2_hi),
        .center    (s2_center)
    );

    // Stages 3 and 4: normal sign, contact point, saturation, output register
    logic signed [FIELD_WIDTH-1:0] contact_f [AXES];

    acg_contact #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_contact (
        .clk             (clk),
        .load            (load),
        .sel_hit         (s2_hit),
        .sel_axis        (s2_axis),
        .sel_pen         (s2_pen),
        .sel_sum_a       (s2_sum_a),
        .sel_sum_b       (s2_sum_b),
        .sel_lo          (s2_lo),
        .sel_hi          (s2_hi),
        .center          (s2_center),
        .colliding       (colliding),
        .normal_axis     (normal_axis),
        .normal_negative (normal_negative),
        .penetration     (penetration),
        .contact         (contact_f)
    );

    assign contact_x = contact_f[AXIS_X];
    assign contact_y = contact_f[AXIS_Y];
    assign contact_z = contact_f[AXIS_Z];

endmodule

FILE: bench/aabb_contact_generator_tb.sv
`timescale 1ns / 1ps

module aabb_contact_generator_tb;

    localparam int FW = acg_pkg::FIELD_WIDTH;
    localparam int AXES = acg_pkg::AXES;

    // Q16.16 one, and the signed range a contact coordinate saturates to
    localparam longint UNIT = 65536;
    localparam longint COORD_HI = (longint'(1) << (FW - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam longint DEPTH_MAX = (longint'(1) << FW) - 1;

    // Pipeline is four deep; give the drain some slack past that
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF_LEN = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef logic [FW-1:0] coord_t;

    // Index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        coord_t [AXES-1:0] a_min;
        coord_t [AXES-1:0] a_max;
        coord_t [AXES-1:0] b_min;
        coord_t [AXES-1:0] b_max;
    } box_pair_t;

    typedef struct packed {
        logic              colliding;
        acg_pkg::axis_t    axis;
        logic              neg;
        logic [FW-1:0]     depth;
        coord_t [AXES-1:0] point;
    } contact_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;

    logic   box_valid = 1'b0;
    logic   box_stall;
    coord_t a_min_x = '0;
    coord_t a_min_y = '0;
    coord_t a_min_z = '0;
    coord_t a_max_x = '0;
    coord_t a_max_y = '0;
    coord_t a_max_z = '0;
    coord_t b_min_x = '0;
    coord_t b_min_y = '0;
    coord_t b_min_z = '0;
    coord_t b_max_x = '0;
    coord_t b_max_y = '0;
    coord_t b_max_z = '0;

    logic   contact_valid;
    logic   contact_stall = 1'b0;
    logic   colliding;
    logic [1:0] normal_axis;
    logic   normal_negative;
    logic [FW-1:0] penetration;
    coord_t contact_x;
    coord_t contact_y;
    coord_t contact_z;

    // Idle odds in percent, set per phase by the test tasks
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    // Long receiver hold-off: request a length, the hold process counts it out
    int unsigned hold_off_cycles = 0;
    logic        hold_off = 1'b0;

    contact_t    expected_contacts[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    aabb_contact_generator dut (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Contact predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_coord(longint v);
        if (v > COORD_HI)
            return COORD_HI;
        if (v < COORD_LO)
            return COORD_LO;
        return v;
    endfunction

    function automatic contact_t predict_contact(box_pair_t bp);
        longint   amin [AXES];
        longint   amax [AXES];
        longint   bmin [AXES];
        longint   bmax [AXES];
        longint   depth [AXES];
        longint   least;
        longint   c;
        int       ax;
        bit       hit;
        contact_t r;
        r = '0;
        hit = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            amin[i] = longint'($signed(bp.a_min[i]));
            amax[i] = longint'($signed(bp.a_max[i]));
            bmin[i] = longint'($signed(bp.b_min[i]));
            bmax[i] = longint'($signed(bp.b_max[i]));
            // Strict overlap: touching faces do not count
            if (!(amax[i] > bmin[i] && amin[i] < bmax[i]))
                hit = 1'b0;
        end
        if (!hit)
            return r;

        for (int i = 0; i < AXES; i++)
            depth[i] = (amax[i] < bmax[i] ? amax[i] : bmax[i])
                     - (amin[i] > bmin[i] ? amin[i] : bmin[i]);

        // Least penetration; ties keep the lower axis
        ax = 0;
        least = depth[0];
        for (int i = 1; i < AXES; i++)
        begin
            if (depth[i] < least)
            begin
                least = depth[i];
                ax = i;
            end
        end

        // Compare center sums so no rounding enters the sign
        r.neg = (bmin[ax] + bmax[ax]) < (amin[ax] + amax[ax]);

        for (int i = 0; i < AXES; i++)
        begin
            if (i == ax)
                c = r.neg ? amin[i] + least : amax[i] - least;
            else
                c = (amin[i] + amax[i]) >>> 1;
            r.point[i] = coord_t'(clamp_coord(c));
        end

        r.colliding = 1'b1;
        r.axis = acg_pkg::axis_t'(ax);
        // Inverted boxes can yield a negative depth; report it as zero
        if (least < 0)
            r.depth = '0;
        else if (least > DEPTH_MAX)
            r.depth = '1;
        else
            r.depth = FW'(least);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Arguments go axis by axis: a_min, a_max, b_min, b_max for x, y, then z
    function automatic box_pair_t pair_of(
        longint ax0, longint ax1, longint bx0, longint bx1,
        longint ay0, longint ay1, longint by0, longint by1,
        longint az0, longint az1, longint bz0, longint bz1);
        box_pair_t bp;
        bp.a_min = {coord_t'(az0), coord_t'(ay0), coord_t'(ax0)};
        bp.a_max = {coord_t'(az1), coord_t'(ay1), coord_t'(ax1)};
        bp.b_min = {coord_t'(bz0), coord_t'(by0), coord_t'(bx0)};
        bp.b_max = {coord_t'(bz1), coord_t'(by1), coord_t'(bx1)};
        return bp;
    endfunction

    function automatic longint rand_position();
        case ($urandom_range(3))
            0: return longint'($signed($urandom));
            1: return (longint'($urandom_range(200)) - 100) * UNIT;
            2: return COORD_HI - longint'($urandom_range(32'd1 << 20));
            default: return COORD_LO + longint'($urandom_range(32'd1 << 20));
        endcase
    endfunction

    // Spans from one LSB up to 2^30; short spans make depth ties likely
    function automatic longint rand_span();
        int unsigned sh;
        sh = $urandom_range(30);
        return longint'($urandom_range(32'd1 << sh, 1));
    endfunction

    function automatic void fill_axis(inout box_pair_t bp, input int i, input bit overlap);
        longint lo, sa, sb, off, alo, ahi, blo, bhi, tmp;
        lo = rand_position();
        sa = rand_span();
        sb = rand_span();
        if (overlap)
            off = longint'($urandom_range(32'(sa + sb - 2), 0)) - (sb - 1);
        else if ($urandom_range(1))
            off = sa + longint'($urandom_range(3));      // touching or just past A
        else
            off = -sb - longint'($urandom_range(3));     // touching or just below A
        alo = clamp_coord(lo);
        ahi = clamp_coord(lo + sa);
        blo = clamp_coord(lo + off);
        bhi = clamp_coord(lo + off + sb);
        // Now and then turn a box inside out
        if ($urandom_range(15) == 0)
        begin
            tmp = alo;
            alo = ahi;
            ahi = tmp;
        end
        if ($urandom_range(15) == 0)
        begin
            tmp = blo;
            blo = bhi;
            bhi = tmp;
        end
        bp.a_min[i] = coord_t'(alo);
        bp.a_max[i] = coord_t'(ahi);
        bp.b_min[i] = coord_t'(blo);
        bp.b_max[i] = coord_t'(bhi);
    endfunction

    // Mostly overlapping pairs, some near misses on one axis, some raw noise
    function automatic box_pair_t random_box_pair();
        box_pair_t   bp;
        int unsigned kind;
        int unsigned apart;
        kind = $urandom_range(99);
        apart = $urandom_range(AXES - 1);
        for (int i = 0; i < AXES; i++)
        begin
            if (kind < 15)
            begin
                bp.a_min[i] = $urandom;
                bp.a_max[i] = $urandom;
                bp.b_min[i] = $urandom;
                bp.b_max[i] = $urandom;
            end
            else
                fill_axis(bp, i, !(kind >= 85 && i == apart));
        end
        return bp;
    endfunction

    // ------------------------------------------------------------------
    // Box channel driver
    // ------------------------------------------------------------------

    // Drive one transaction and hold it until the block takes it. Decide
    // acceptance at the falling edge, where every signal has settled.
    task automatic send_boxes(box_pair_t bp);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            box_valid <= 1'b0;
            @(posedge clk);
        end
        box_valid <= 1'b1;
        a_min_x <= bp.a_min[0];
        a_min_y <= bp.a_min[1];
        a_min_z <= bp.a_min[2];
        a_max_x <= bp.a_max[0];
        a_max_y <= bp.a_max[1];
        a_max_z <= bp.a_max[2];
        b_min_x <= bp.b_min[0];
        b_min_y <= bp.b_min[1];
        b_min_z <= bp.b_min[2];
        b_max_x <= bp.b_max[0];
        b_max_y <= bp.b_max[1];
        b_max_z <= bp.b_max[2];
        do
        begin
            @(negedge clk);
            taken = !box_stall;
            @(posedge clk);
        end
        while (!taken);
        expected_contacts.push_back(predict_contact(bp));
    endtask

    // Drop valid and wait until every predicted contact has come back
    task automatic drain_contacts();
        box_valid <= 1'b0;
        while (expected_contacts.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Contact channel: stall generator and long hold-off
    // ------------------------------------------------------------------

    always @(posedge clk)
        contact_stall <= hold_off || ($urandom_range(99) < stall_pct);

    // Count the hold-off on falling edges so it never races the stall draw
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles != 0)
            begin
                hold_off = 1'b1;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off = 1'b0;
                hold_off_cycles = 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Contact checker
    // ------------------------------------------------------------------

    task automatic compare_field(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // A contact transaction completes at the next rising edge; the outputs
    // cannot move before then, so compare them here.
    always @(negedge clk)
    begin : check_contact
        contact_t want;
        if (rst_n && contact_valid && !contact_stall)
        begin
            if (expected_contacts.size() == 0)
            begin
                $display("%0t: unexpected contact transaction, expected none, %s%b",
                         $time, "actual colliding=", colliding);
                mismatch_count++;
            end
            else
            begin
                want = expected_contacts.pop_front();
                compare_field("colliding", want.colliding, colliding);
                compare_field("normal_axis", want.axis, normal_axis);
                compare_field("normal_negative", want.neg, normal_negative);
                compare_field("penetration", want.depth, penetration);
                compare_field("contact_x", want.point[0], contact_x);
                compare_field("contact_y", want.point[1], contact_y);
                compare_field("contact_z", want.point[2], contact_z);
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked pairs: axis choice, ties, normal signs, touching faces,
    // full-range and inside-out boxes.
    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct = 0;
        // x shallowest, B to the right
        send_boxes(pair_of(0, 10*UNIT, 8*UNIT, 20*UNIT,
                           0, 10*UNIT, -5*UNIT, 15*UNIT,
                           0, 10*UNIT, -5*UNIT, 15*UNIT));
        // x shallowest, B to the left
        send_boxes(pair_of(0, 10*UNIT, -8*UNIT, 2*UNIT,
                           0, 10*UNIT, -5*UNIT, 15*UNIT,
                           0, 10*UNIT, -5*UNIT, 15*UNIT));
        // y shallowest, B below
        send_boxes(pair_of(0, 10*UNIT, -5*UNIT, 15*UNIT,
                           0, 10*UNIT, -3*UNIT, 1*UNIT,
                           0, 10*UNIT, -5*UNIT, 15*UNIT));
        // z shallowest, B below
        send_boxes(pair_of(0, 10*UNIT, -5*UNIT, 15*UNIT,
                           0, 10*UNIT, -5*UNIT, 15*UNIT,
                           0, 10*UNIT, -4*UNIT, 2*UNIT));
        // z shallowest, B above
        send_boxes(pair_of(0, 10*UNIT, -5*UNIT, 15*UNIT,
                           0, 10*UNIT, -5*UNIT, 15*UNIT,
                           0, 10*UNIT, 9*UNIT, 12*UNIT));
        // x and y tie: x wins
        send_boxes(pair_of(0, 10*UNIT, 8*UNIT, 20*UNIT,
                           0, 10*UNIT, 8*UNIT, 20*UNIT,
                           0, 10*UNIT, 0, 10*UNIT));
        // y and z tie: y wins
        send_boxes(pair_of(0, 10*UNIT, -5*UNIT, 15*UNIT,
                           0, 10*UNIT, 7*UNIT, 20*UNIT,
                           0, 10*UNIT, 7*UNIT, 20*UNIT));
        // identical boxes: equal centers keep a positive normal
        send_boxes(pair_of(1, 3, 1, 3, 1, 3, 1, 3, 1, 3, 1, 3));
        // faces touching on x, then on y, then on z: no contact
        send_boxes(pair_of(0, 10*UNIT, 10*UNIT, 20*UNIT,
                           0, 10*UNIT, 0, 10*UNIT,
                           0, 10*UNIT, 0, 10*UNIT));
        send_boxes(pair_of(0, 10*UNIT, 0, 10*UNIT,
                           0, 10*UNIT, -10*UNIT, 0,
                           0, 10*UNIT, 0, 10*UNIT));
        send_boxes(pair_of(0, 10*UNIT, 0, 10*UNIT,
                           0, 10*UNIT, 0, 10*UNIT,
                           0, 10*UNIT, 10*UNIT, 11*UNIT));
        // apart on z by one LSB
        send_boxes(pair_of(0, 10, 0, 10, 0, 10, 0, 10, 0, 10, -5, -1));
        // both boxes span the whole coordinate range
        send_boxes(pair_of(COORD_LO, COORD_HI, COORD_LO, COORD_HI,
                           COORD_LO, COORD_HI, COORD_LO, COORD_HI,
                           COORD_LO, COORD_HI, COORD_LO, COORD_HI));
        // tiny B against the lower corner of a full-range A
        send_boxes(pair_of(COORD_LO, COORD_HI, COORD_LO, COORD_LO + 1,
                           COORD_LO, COORD_HI, COORD_LO, COORD_LO + 2,
                           COORD_LO, COORD_HI, COORD_LO, COORD_LO + 3));
        // tiny B against the upper corner
        send_boxes(pair_of(COORD_LO, COORD_HI, COORD_HI - 1, COORD_HI,
                           COORD_LO, COORD_HI, COORD_HI - 2, COORD_HI,
                           COORD_LO, COORD_HI, COORD_HI - 3, COORD_HI));
        // every field at one extreme, then the other: no contact
        send_boxes(pair_of(COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                           COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                           COORD_LO, COORD_LO, COORD_LO, COORD_LO));
        send_boxes(pair_of(COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                           COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                           COORD_HI, COORD_HI, COORD_HI, COORD_HI));
        // inside-out A on x: negative depth, reported as zero
        send_boxes(pair_of(100*UNIT, 50*UNIT, 0, 200*UNIT,
                           0, 300*UNIT, 0, 300*UNIT,
                           0, 300*UNIT, 0, 300*UNIT));
        // inside-out A spanning the extremes
        send_boxes(pair_of(COORD_HI - 1, COORD_LO + 1, COORD_LO, COORD_HI,
                           COORD_LO, COORD_HI, COORD_LO, COORD_HI,
                           COORD_LO, COORD_HI, COORD_LO, COORD_HI));
        // inside-out B that still passes the overlap test
        send_boxes(pair_of(0, 10*UNIT, 8*UNIT, 2*UNIT,
                           0, 10*UNIT, 0, 10*UNIT,
                           0, 10*UNIT, 0, 10*UNIT));
        // negative fractional coordinates, odd sums for the center floor
        send_boxes(pair_of(-3*UNIT - 1, -UNIT, -2*UNIT, 0,
                           -7, 2, -6, 5,
                           -9, -2, -12, -4));
        drain_contacts();
    endtask

    task automatic run_random_boxes(int count, int unsigned idle, int unsigned stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (count) send_boxes(random_box_pair());
        drain_contacts();
    endtask

    task automatic test_random_free_flow();
        run_random_boxes(375, 0, 0);
    endtask

    task automatic test_random_sender_gaps();
        run_random_boxes(375, 63, 0);
    endtask

    task automatic test_random_receiver_stalls();
        run_random_boxes(375, 0, 63);
    endtask

    task automatic test_random_both_idle();
        run_random_boxes(375, 34, 34);
    endtask

    // Hold the contact side off while boxes keep coming, so the pipeline
    // fills and the block must stall its input without losing anything.
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (60) send_boxes(random_box_pair());
        drain_contacts();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_free_flow();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        test_output_hold_off();

        // Let any stray transaction show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_contacts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
